FILE: design/ppls_pkg.sv
// shared types and constants for the phong point light shader
// no dependencies
package ppls_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 2'd2;

    // arithmetic constants
    localparam logic [15:0] AMBIENT_Q16 = 16'd58982;
    localparam logic [19:0] SPEC_CAP    = 20'd524288;
    localparam int          SQUARINGS   = 8;

    // normalize unit depth: mag/shift, squares, sum, root steps, divide steps, sign
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 17;
    localparam int NORM_LAT    = 3 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int POST_STAGES = 6 + SQUARINGS + 3;
    localparam int PIPE_LAST   = NORM_LAT + POST_STAGES;

    // three 33 bit differences in, three Q.16 unit components out
    typedef logic [2:0][32:0] t_dvec;
    typedef logic [2:0][17:0] t_uvec;

    typedef struct packed {
        logic [15:0]        surf_red;
        logic [15:0]        surf_green;
        logic [15:0]        surf_blue;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
    } t_in_item;

    typedef struct packed {
        logic [15:0] lit_red;
        logic [15:0] lit_green;
        logic [15:0] lit_blue;
    } t_out_item;

endpackage

FILE: design/ppls_norm.sv
// pipelined vector normalizer: prescale, squares, integer root, long division
// depends on ppls_pkg
module ppls_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  ppls_pkg::t_dvec i_vec,
    output ppls_pkg::t_uvec o_unit
);
    import ppls_pkg::*;

    typedef struct packed {
        logic [2:0][29:0] a;
        logic [2:0]       neg;
    } t_nside;

    // prescale
    logic [2:0][31:0] n_mag;
    logic [31:0]      n_mx;
    t_nside           n_sd_a;
    t_nside           r_sd_a;

    // squares and sum
    logic [2:0][59:0] n_sq;
    logic [2:0][59:0] r_sq;
    t_nside           r_sd_b;

    // root iterations
    logic [63:0] r_x [0:SQRT_STEPS];
    logic [63:0] r_r [0:SQRT_STEPS];
    t_nside      r_sd_s [0:SQRT_STEPS];
    logic [63:0] n_x [1:SQRT_STEPS];
    logic [63:0] n_r [1:SQRT_STEPS];
    logic [63:0] w_t [0:SQRT_STEPS-1];

    // division iterations
    logic [2:0][31:0] w_sh  [0:DIV_STEPS-1];
    logic [2:0][16:0] w_qin [0:DIV_STEPS-1];
    logic [30:0]      w_len [0:DIV_STEPS-1];
    logic [2:0]       w_neg [0:DIV_STEPS-1];
    logic [2:0][30:0] n_rem [1:DIV_STEPS];
    logic [2:0][16:0] n_q   [1:DIV_STEPS];
    logic [2:0][30:0] r_rem [1:DIV_STEPS];
    logic [2:0][16:0] r_q   [1:DIV_STEPS];
    logic [30:0]      r_dlen [1:DIV_STEPS];
    logic [2:0]       r_dneg [1:DIV_STEPS];

    t_uvec n_out;
    t_uvec r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][32] ? 32'(33'd0 - i_vec[i]) : i_vec[i][31:0];
            n_sd_a.neg[i] = i_vec[i][32];
        end
        n_mx = n_mag[0];
        if (n_mag[1] > n_mx) begin
            n_mx = n_mag[1];
        end
        if (n_mag[2] > n_mx) begin
            n_mx = n_mag[2];
        end
        for (int i = 0; i < 3; i++) begin
            priority if (n_mx[31]) begin
                n_sd_a.a[i] = n_mag[i][31:2];
            end else if (n_mx[30]) begin
                n_sd_a.a[i] = n_mag[i][30:1];
            end else begin
                n_sd_a.a[i] = n_mag[i][29:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = 60'(r_sd_a.a[i]) * 60'(r_sd_a.a[i]);
        end
    end

    // one root bit per stage, trial bit 4^(31-j)
    always_comb begin
        for (int j = 0; j < SQRT_STEPS; j++) begin
            w_t[j] = r_r[j] + (64'd1 << (62 - 2 * j));
            if (r_x[j] >= w_t[j]) begin
                n_x[j+1] = r_x[j] - w_t[j];
                n_r[j+1] = (r_r[j] >> 1) + (64'd1 << (62 - 2 * j));
            end else begin
                n_x[j+1] = r_x[j];
                n_r[j+1] = r_r[j] >> 1;
            end
        end
    end

    // quotient is below 2^17, so the upper dividend bits collapse into a start remainder of a
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                w_len[k] = r_r[SQRT_STEPS][30:0];
                w_neg[k] = r_sd_s[SQRT_STEPS].neg;
            end else begin
                w_len[k] = r_dlen[k];
                w_neg[k] = r_dneg[k];
            end
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    w_sh[k][i]  = {2'b00, r_sd_s[SQRT_STEPS].a[i]};
                    w_qin[k][i] = '0;
                end else begin
                    w_sh[k][i]  = {r_rem[k][i], 1'b0};
                    w_qin[k][i] = r_q[k][i];
                end
                if (w_sh[k][i] >= {1'b0, w_len[k]}) begin
                    n_rem[k+1][i] = 31'(w_sh[k][i] - {1'b0, w_len[k]});
                    n_q[k+1][i]   = {w_qin[k][i][15:0], 1'b1};
                end else begin
                    n_rem[k+1][i] = w_sh[k][i][30:0];
                    n_q[k+1][i]   = {w_qin[k][i][15:0], 1'b0};
                end
            end
        end
    end

    // zero length vector gives a zero unit vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dlen[DIV_STEPS] == '0) begin
                n_out[i] = '0;
            end else if (r_dneg[DIV_STEPS][i]) begin
                n_out[i] = 18'd0 - {1'b0, r_q[DIV_STEPS][i]};
            end else begin
                n_out[i] = {1'b0, r_q[DIV_STEPS][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd_a    <= n_sd_a;
            r_sq      <= n_sq;
            r_sd_b    <= r_sd_a;
            r_x[0]    <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_r[0]    <= '0;
            r_sd_s[0] <= r_sd_b;
            for (int j = 1; j <= SQRT_STEPS; j++) begin
                r_x[j]    <= n_x[j];
                r_r[j]    <= n_r[j];
                r_sd_s[j] <= r_sd_s[j-1];
            end
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_dlen[k] <= w_len[k-1];
                r_dneg[k] <= w_neg[k-1];
            end
            r_out <= n_out;
        end
    end

    assign o_unit = r_out;

endmodule

FILE: design/phong_point_light_shader_top.sv
// phong point light shader: normalizes L, N, V, forms diffuse and specular terms
// depends on ppls_pkg and ppls_norm
//
// channel   direction  handshake              payload
// item in   input      i_valid / o_stall      i_item  (ppls_pkg::t_in_item)
// result    output     o_valid / i_stall      o_item  (ppls_pkg::t_out_item)
// config    input      i_cfg_we               i_cfg_idx, i_cfg_data
//
// one item enters per cycle while o_stall is low; the pipeline depth is set by the 32
// integer root steps and 17 divide steps of the normalizer and the eight specular
// squarings. all stages move together: when a result sits in the output register
// under stall, the pipeline holds and o_stall rises.
// synchronous reset clears the valid line and the light position.
module phong_point_light_shader_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ppls_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ppls_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import ppls_pkg::*;

    typedef struct packed {
        logic [2:0][15:0] col;
        logic [2:0][15:0] nr;
    } t_side;

    logic w_en;
    logic [PIPE_LAST:0] r_vld;

    logic signed [31:0] r_light_x;
    logic signed [31:0] r_light_y;
    logic signed [31:0] r_light_z;

    // stage 0
    t_dvec r_dl;
    t_dvec r_dv;
    t_dvec r_dn;
    t_side n_side;
    t_side r_dly [0:NORM_LAT];

    t_uvec w_lu;
    t_uvec w_nu;
    t_uvec w_vu;

    logic signed [17:0] w_l  [0:2];
    logic signed [17:0] w_n  [0:2];
    logic signed [17:0] w_v  [0:2];
    logic signed [15:0] w_nr [0:2];

    // dot products
    logic signed [35:0] r_p1_pd [0:2];
    logic signed [33:0] r_p1_pk [0:2];
    logic signed [17:0] r_p1_l  [0:2];
    logic signed [17:0] r_p1_v  [0:2];
    logic signed [15:0] r_p1_nr [0:2];
    logic [2:0][15:0]   r_p1_col;

    logic signed [37:0] n_d;
    logic signed [35:0] n_k;
    logic signed [35:0] r_p2_k;
    logic [17:0]        r_p2_diff;
    logic signed [17:0] r_p2_l  [0:2];
    logic signed [17:0] r_p2_v  [0:2];
    logic signed [15:0] r_p2_nr [0:2];
    logic [2:0][15:0]   r_p2_col;

    // reflection vector
    logic signed [52:0] r_p3_t [0:2];
    logic signed [17:0] r_p3_l [0:2];
    logic signed [17:0] r_p3_v [0:2];
    logic [17:0]        r_p3_diff;
    logic [2:0][15:0]   r_p3_col;

    logic signed [53:0] n_rv  [0:2];
    logic [53:0]        n_rm  [0:2];
    logic signed [25:0] n_r   [0:2];
    logic signed [25:0] r_p4_r [0:2];
    logic signed [17:0] r_p4_v [0:2];
    logic [17:0]        r_p4_diff;
    logic [2:0][15:0]   r_p4_col;

    logic signed [43:0] r_p5_ps [0:2];
    logic [17:0]        r_p5_diff;
    logic [2:0][15:0]   r_p5_col;

    // specular power
    logic signed [45:0] n_s;
    logic [19:0]        n_spec0;
    logic [19:0]        r_spec  [0:SQUARINGS];
    logic [17:0]        r_sq_diff [0:SQUARINGS];
    logic [2:0][15:0]   r_sq_col  [0:SQUARINGS];
    logic [39:0]        n_pw   [1:SQUARINGS];
    logic [19:0]        n_spec [1:SQUARINGS];

    // color scale
    logic [20:0]      r_int;
    logic [2:0][15:0] r_p15_col;
    logic [36:0]      r_prod [0:2];
    t_out_item        n_out;
    t_out_item        r_out;

    assign w_en    = ~(r_vld[PIPE_LAST] & i_stall);
    assign o_stall = ~w_en;
    assign o_valid = r_vld[PIPE_LAST];
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIGHT_X: r_light_x <= i_cfg_data;
                CFG_LIGHT_Y: r_light_y <= i_cfg_data;
                CFG_LIGHT_Z: r_light_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAST-1:0], i_valid};
        end
    end

    assign n_side.col = {i_item.surf_red, i_item.surf_green, i_item.surf_blue};
    assign n_side.nr  = {i_item.norm_x, i_item.norm_y, i_item.norm_z};

    // differences are exact in 33 bits; element 2 is x
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[2] <= {r_light_x[31], r_light_x} - {i_item.hit_x[31], i_item.hit_x};
            r_dl[1] <= {r_light_y[31], r_light_y} - {i_item.hit_y[31], i_item.hit_y};
            r_dl[0] <= {r_light_z[31], r_light_z} - {i_item.hit_z[31], i_item.hit_z};
            r_dv[2] <= {i_item.view_x[31], i_item.view_x} - {i_item.hit_x[31], i_item.hit_x};
            r_dv[1] <= {i_item.view_y[31], i_item.view_y} - {i_item.hit_y[31], i_item.hit_y};
            r_dv[0] <= {i_item.view_z[31], i_item.view_z} - {i_item.hit_z[31], i_item.hit_z};
            r_dn[2] <= {{17{i_item.norm_x[15]}}, i_item.norm_x};
            r_dn[1] <= {{17{i_item.norm_y[15]}}, i_item.norm_y};
            r_dn[0] <= {{17{i_item.norm_z[15]}}, i_item.norm_z};
            r_dly[0] <= n_side;
            for (int k = 1; k <= NORM_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    ppls_norm u_norm_l (.i_clk(i_clk), .i_en(w_en), .i_vec(r_dl), .o_unit(w_lu));
    ppls_norm u_norm_n (.i_clk(i_clk), .i_en(w_en), .i_vec(r_dn), .o_unit(w_nu));
    ppls_norm u_norm_v (.i_clk(i_clk), .i_en(w_en), .i_vec(r_dv), .o_unit(w_vu));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_l[i]  = $signed(w_lu[i]);
            w_n[i]  = $signed(w_nu[i]);
            w_v[i]  = $signed(w_vu[i]);
            w_nr[i] = $signed(r_dly[NORM_LAT].nr[i]);
        end
    end

    always_comb begin
        n_d = 38'(r_p1_pd[0]) + 38'(r_p1_pd[1]) + 38'(r_p1_pd[2]);
        n_k = 36'(r_p1_pk[0]) + 36'(r_p1_pk[1]) + 36'(r_p1_pk[2]);
        for (int i = 0; i < 3; i++) begin
            // truncate toward zero
            n_rv[i] = 54'(r_p3_t[i]) - (54'(r_p3_l[i]) <<< 28);
            n_rm[i] = n_rv[i][53] ? (54'd0 - n_rv[i]) >> 28 : n_rv[i] >> 28;
            n_r[i]  = n_rv[i][53] ? 26'(54'd0 - n_rm[i]) : 26'(n_rm[i]);
        end
        n_s = 46'(r_p5_ps[0]) + 46'(r_p5_ps[1]) + 46'(r_p5_ps[2]);
        if (n_s <= 46'sd0) begin
            n_spec0 = '0;
        end else if (n_s[45:16] > 30'(SPEC_CAP)) begin
            n_spec0 = SPEC_CAP;
        end else begin
            n_spec0 = n_s[35:16];
        end
        for (int j = 1; j <= SQUARINGS; j++) begin
            n_pw[j] = 40'(r_spec[j-1]) * 40'(r_spec[j-1]);
            if (n_pw[j][39:16] > 24'(SPEC_CAP)) begin
                n_spec[j] = SPEC_CAP;
            end else begin
                n_spec[j] = n_pw[j][35:16];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r_prod[2-i][36:18] > 19'd65535) begin
                n_out[47-16*i -: 16] = 16'hFFFF;
            end else begin
                n_out[47-16*i -: 16] = r_prod[2-i][33:18];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1_pd[i] <= 36'(w_n[i]) * 36'(w_l[i]);
                r_p1_pk[i] <= 34'(w_l[i]) * 34'(w_nr[i]);
                r_p1_l[i]  <= w_l[i];
                r_p1_v[i]  <= w_v[i];
                r_p1_nr[i] <= w_nr[i];

                r_p2_l[i]  <= r_p1_l[i];
                r_p2_v[i]  <= r_p1_v[i];
                r_p2_nr[i] <= r_p1_nr[i];

                r_p3_t[i] <= (53'(r_p2_k) * 53'(r_p2_nr[i])) <<< 1;
                r_p3_l[i] <= r_p2_l[i];
                r_p3_v[i] <= r_p2_v[i];

                r_p4_r[i] <= n_r[i];
                r_p4_v[i] <= r_p3_v[i];

                r_p5_ps[i] <= 44'(r_p4_v[i]) * 44'(r_p4_r[i]);

                r_prod[i] <= 37'(r_int) * 37'(r_p15_col[i]);
            end
            r_p1_col <= r_dly[NORM_LAT].col;

            r_p2_k    <= n_k;
            r_p2_diff <= (n_d > 38'sd0) ? n_d[33:16] : '0;
            r_p2_col  <= r_p1_col;

            r_p3_diff <= r_p2_diff;
            r_p3_col  <= r_p2_col;
            r_p4_diff <= r_p3_diff;
            r_p4_col  <= r_p3_col;
            r_p5_diff <= r_p4_diff;
            r_p5_col  <= r_p4_col;

            r_spec[0]    <= n_spec0;
            r_sq_diff[0] <= r_p5_diff;
            r_sq_col[0]  <= r_p5_col;
            for (int j = 1; j <= SQUARINGS; j++) begin
                r_spec[j]    <= n_spec[j];
                r_sq_diff[j] <= r_sq_diff[j-1];
                r_sq_col[j]  <= r_sq_col[j-1];
            end

            r_int     <= 21'(AMBIENT_Q16) + 21'(r_sq_diff[SQUARINGS]) + 21'(r_spec[SQUARINGS]);
            r_p15_col <= r_sq_col[SQUARINGS];

            r_out <= n_out;
        end
    end

endmodule

FILE: verif/phong_point_light_shader_top_test.sv
// testbench for phong_point_light_shader_top: random and directed hit records with
// light positions changed between phases, results checked against a local shading model
// depends on ppls_pkg and the design files
module phong_point_light_shader_top_test;
    import ppls_pkg::*;

    localparam int LAT        = PIPE_LAST + 1;
    localparam int CYCLE_CAP  = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_item;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    phong_point_light_shader_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    t_in_item  pending_hits[$];
    t_out_item expected_colors[$];
    logic signed [31:0] light_pos[3];
    int mismatches;
    int cycles;
    int send_gap;
    int recv_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q.16, zero vector stays zero
    task automatic normalize(input longint d[3], output longint u[3]);
        longint unsigned a[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint q;
        int s;
        mx = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = mag(d[i]);
            if (a[i] > mx) mx = a[i];
        end
        while ((mx >> s) >= (64'd1 << 30)) s++;
        for (int i = 0; i < 3; i++) begin
            a[i] >>= s;
            sum += a[i] * a[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (len != 0) ? longint'((a[i] << 16) / len) : 0;
            u[i] = d[i] < 0 ? -q : q;
        end
    endtask

    function automatic longint shr_trunc(longint x, int s);
        longint m;
        m = longint'(mag(x) >> s);
        return x < 0 ? -m : m;
    endfunction

    task automatic shade(input t_in_item it, output t_out_item res);
        longint hit[3], nr[3], vw[3], dl[3], dv[3];
        longint lv[3], nv[3], vv[3], rv[3];
        longint d, k, sd;
        longint unsigned spec, diff, inten, v;
        longint unsigned col[3];
        hit = '{it.hit_x, it.hit_y, it.hit_z};
        nr  = '{it.norm_x, it.norm_y, it.norm_z};
        vw  = '{it.view_x, it.view_y, it.view_z};
        col = '{it.surf_red, it.surf_green, it.surf_blue};
        for (int i = 0; i < 3; i++) begin
            dl[i] = longint'(light_pos[i]) - hit[i];
            dv[i] = vw[i] - hit[i];
        end
        normalize(dl, lv);
        normalize(nr, nv);
        normalize(dv, vv);
        d = nv[0]*lv[0] + nv[1]*lv[1] + nv[2]*lv[2];
        diff = d > 0 ? longint'(d) >> 16 : 0;
        k = lv[0]*nr[0] + lv[1]*nr[1] + lv[2]*nr[2];
        for (int i = 0; i < 3; i++)
            rv[i] = shr_trunc(2*k*nr[i] - lv[i]*(longint'(1) << 28), 28);
        sd = vv[0]*rv[0] + vv[1]*rv[1] + vv[2]*rv[2];
        spec = sd > 0 ? longint'(sd) >> 16 : 0;
        if (spec > SPEC_CAP) spec = SPEC_CAP;
        for (int i = 0; i < SQUARINGS; i++) begin
            spec = (spec * spec) >> 16;
            if (spec > SPEC_CAP) spec = SPEC_CAP;
        end
        inten = AMBIENT_Q16 + diff + spec;
        for (int i = 0; i < 3; i++) begin
            v = (inten * col[i]) >> 18;
            col[i] = v > 65535 ? 65535 : v;
        end
        res.lit_red = col[0][15:0];
        res.lit_green = col[1][15:0];
        res.lit_blue = col[2][15:0];
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic logic [15:0] rand_norm();
        case ($urandom_range(0, 7))
            0: return 16'($urandom());
            1: return 16'sd0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] rand_color();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic t_in_item rand_hit();
        t_in_item it;
        it.surf_red = rand_color();
        it.surf_green = rand_color();
        it.surf_blue = rand_color();
        it.hit_x = rand_coord();
        it.hit_y = rand_coord();
        it.hit_z = rand_coord();
        it.norm_x = rand_norm();
        it.norm_y = rand_norm();
        it.norm_z = rand_norm();
        it.view_x = rand_coord();
        it.view_y = rand_coord();
        it.view_z = rand_coord();
        // often place the viewer on the mirror direction of the light to light up specular
        if ($urandom_range(0, 3) == 0) begin
            it.view_x = -light_pos[0];
            it.view_y = -light_pos[1];
            it.view_z = light_pos[2];
            it.hit_x = 0;
            it.hit_y = 0;
            it.hit_z = 0;
            it.norm_x = '0;
            it.norm_y = '0;
            it.norm_z = 16'sd16384;
        end
        return it;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    task automatic write_light(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        light_pos[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_hit(input t_in_item it);
        t_out_item res;
        shade(it, res);
        expected_colors = {expected_colors, res};
        pending_hits = {pending_hits, it};
    endtask

    task automatic drain();
        while (pending_hits.size() != 0 || expected_colors.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) void'(pending_hits.pop_front());
            if (i_valid && o_stall) begin
                // hold the stalled transfer
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_hits.size() > (i_valid && !o_stall ? 0 : 0)
                         && pending_hits.size() != 0) begin
                i_valid <= 1'b1;
                i_item <= pending_hits[0];
                send_gap <= rand_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_item);
                end else begin
                    want = expected_colors.pop_front();
                    if (want !== o_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch r/g/b expected %h %h %h actual %h %h %h",
                                     want.lit_red, want.lit_green, want.lit_blue,
                                     o_item.lit_red, o_item.lit_green, o_item.lit_blue);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                recv_gap <= rand_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL phong_point_light_shader_top");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        logic [31:0] settings[5][3];
        mismatches = 0;
        cycles = 0;
        light_pos = '{0, 0, 0};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LIGHT_X;
        i_cfg_data = '0;
        send_gap = 0;
        recv_gap = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, light at reset position (origin)
        it = '0;
        queue_hit(it);                                   // every vector zero
        it.surf_red = 16'd32768; it.surf_green = 16'hffff; it.surf_blue = 16'd1;
        it.norm_z = 16'sd16384; it.hit_z = -32'sd65536; it.view_z = -32'sd65536;
        queue_hit(it);                                   // viewer on the hit point
        it.view_z = 32'sd65536;
        queue_hit(it);                                   // mirror direction, full specular
        it.norm_z = -16'sd16384;
        queue_hit(it);                                   // back facing
        it.norm_x = 16'sh7fff; it.norm_y = 16'sh8000; it.norm_z = 16'sh7fff;
        queue_hit(it);                                   // normal outside unit range
        it.hit_x = 32'h80000000; it.hit_y = 32'h7fffffff; it.hit_z = 32'h80000000;
        it.view_x = 32'h7fffffff; it.view_y = 32'h80000000; it.view_z = 32'h7fffffff;
        queue_hit(it);                                   // coordinate extremes
        it.surf_red = 16'hffff; it.surf_green = 16'hffff; it.surf_blue = 16'hffff;
        it.hit_x = 0; it.hit_y = 0; it.hit_z = -32'sd65536;
        it.view_x = 0; it.view_y = 0; it.view_z = 32'sd65536;
        it.norm_x = '0; it.norm_y = '0; it.norm_z = 16'sd16384;
        queue_hit(it);                                   // white surface, mirror direction
        for (int i = 0; i < 8; i++) queue_hit(rand_hit());
        drain();

        settings[0] = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        settings[1] = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        settings[2] = '{32'd0, 32'd0, 32'sd10 << 16};
        settings[3] = '{32'hffffffff, 32'd1, 32'sd3 << 16};
        settings[4] = '{$urandom(), $urandom(), $urandom()};
        for (int p = 0; p < 5; p++) begin
            write_light(CFG_LIGHT_X, settings[p][0]);
            write_light(CFG_LIGHT_Y, settings[p][1]);
            write_light(CFG_LIGHT_Z, settings[p][2]);
            for (int i = 0; i < 140; i++) queue_hit(rand_hit());
            drain();
        end

        if (mismatches == 0) begin
            $display("PASS phong_point_light_shader_top");
        end else begin
            $display("FAIL phong_point_light_shader_top");
        end
        $finish;
    end

    // leftover expectations are caught by drain never ending, which hits the cycle cap
endmodule
